### rtl/s2gt_pkg.sv
package s2gt_pkg;

   localparam int DIMENSIONS         = 2;
   localparam int ADDR_W             = 32;
   localparam int VALUE_W            = 64;
   localparam int NUM_REGS           = 6;
   localparam int PADDR_W            = 5;
   localparam int QUEUE_DEPTH        = 2;
   localparam int OUT_DEPTH          = 2;

   localparam logic [VALUE_W-1:0] ONE_BITS = 64'h3FF0_0000_0000_0000;

   // Register indexes of the configuration port.
   typedef enum logic [2:0] {
      REG_A_ROW   = 3'd0,
      REG_A_COL   = 3'd1,
      REG_B_ROW   = 3'd2,
      REG_B_COL   = 3'd3,
      REG_R_ROW   = 3'd4,
      REG_R_COL   = 3'd5
   } reg_index_type;

   // One classified word passed from the front part to the back part.
   typedef struct packed {
      logic [ADDR_W-1:0]  row_index;
      logic [ADDR_W-1:0]  col_index;
      logic [ADDR_W-1:0]  base_a;
      logic [ADDR_W-1:0]  base_b;
      logic [ADDR_W-1:0]  base_result;
      logic [VALUE_W-1:0] a_value;
      logic [VALUE_W-1:0] b_value;
      logic               last;
   } work_type;

   // Result word held in the output queue.
   typedef struct packed {
      logic [ADDR_W-1:0]  a_address;
      logic [ADDR_W-1:0]  b_address;
      logic [ADDR_W-1:0]  result_address;
      logic               greater;
      logic               last;
   } result_type;

   // Stride set driven by the register file.
   typedef struct packed {
      logic [ADDR_W-1:0] a_row;
      logic [ADDR_W-1:0] a_col;
      logic [ADDR_W-1:0] b_row;
      logic [ADDR_W-1:0] b_col;
      logic [ADDR_W-1:0] r_row;
      logic [ADDR_W-1:0] r_col;
   } stride_type;

   // IEEE double "a > b"; any NaN gives false and +0 equals -0.
   function automatic logic fp_greater(input logic [VALUE_W-1:0] a,
                                       input logic [VALUE_W-1:0] b);
      logic a_nan;
      logic b_nan;
      logic a_zero;
      logic b_zero;
      logic res;
      a_nan  = (a[62:52] == 11'h7FF) && (a[51:0] != '0);
      b_nan  = (b[62:52] == 11'h7FF) && (b[51:0] != '0);
      a_zero = (a[62:0] == '0);
      b_zero = (b[62:0] == '0);
      if (a_nan || b_nan || (a_zero && b_zero)) begin
         res = 1'b0;
      end else if (a[63] != b[63]) begin
         res = b[63];
      end else if (!a[63]) begin
         res = a[62:0] > b[62:0];
      end else begin
         res = a[62:0] < b[62:0];
      end
      return res;
   endfunction

endpackage

### rtl/s2gt_front.sv
module s2gt_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic                          req_kind,
   input  logic [s2gt_pkg::ADDR_W-1:0]   req_row_first,
   input  logic [s2gt_pkg::ADDR_W-1:0]   req_row_end,
   input  logic [s2gt_pkg::ADDR_W-1:0]   req_col_first,
   input  logic [s2gt_pkg::ADDR_W-1:0]   req_col_end,
   input  logic [s2gt_pkg::ADDR_W-1:0]   req_a_base,
   input  logic [s2gt_pkg::ADDR_W-1:0]   req_b_base,
   input  logic [s2gt_pkg::ADDR_W-1:0]   req_result_base,
   input  logic [s2gt_pkg::VALUE_W-1:0]  req_a_value,
   input  logic [s2gt_pkg::VALUE_W-1:0]  req_b_value,
   output logic                          work_valid,
   output s2gt_pkg::work_type            work_word,
   input  logic                          work_full
);
   import s2gt_pkg::*;

   logic [ADDR_W-1:0] row_index_ff, row_index_in;
   logic [ADDR_W-1:0] col_index_ff, col_index_in;
   logic [ADDR_W-1:0] col_start_ff, col_start_in;
   logic [ADDR_W-1:0] row_limit_ff, row_limit_in;
   logic [ADDR_W-1:0] col_limit_ff, col_limit_in;
   logic [ADDR_W-1:0] base_a_ff, base_a_in;
   logic [ADDR_W-1:0] base_b_ff, base_b_in;
   logic [ADDR_W-1:0] base_result_ff, base_result_in;
   logic              running_ff, running_in;
   logic              accept;
   logic [ADDR_W-1:0] next_col;
   logic [ADDR_W-1:0] next_row;
   logic              col_wrap;
   logic              row_done;

   assign req_full = work_full;
   assign accept   = req_push && !req_full;

   // Index stepping; index is below its limit so the increment cannot wrap.
   assign next_col = col_index_ff + 1'b1;
   assign next_row = row_index_ff + 1'b1;
   assign col_wrap = $signed(next_col) >= $signed(col_limit_ff);
   assign row_done = $signed(next_row) >= $signed(row_limit_ff);

   // Loop state update for start and data words.
   always_comb begin
      row_index_in   = row_index_ff;
      col_index_in   = col_index_ff;
      col_start_in   = col_start_ff;
      row_limit_in   = row_limit_ff;
      col_limit_in   = col_limit_ff;
      base_a_in      = base_a_ff;
      base_b_in      = base_b_ff;
      base_result_in = base_result_ff;
      running_in     = running_ff;
      if (accept && !req_kind) begin
         row_index_in   = req_row_first;
         col_index_in   = req_col_first;
         col_start_in   = req_col_first;
         row_limit_in   = req_row_end;
         col_limit_in   = req_col_end;
         base_a_in      = req_a_base;
         base_b_in      = req_b_base;
         base_result_in = req_result_base;
         running_in     = ($signed(req_row_first) < $signed(req_row_end)) &&
                          ($signed(req_col_first) < $signed(req_col_end));
      end else if (accept && running_ff) begin
         if (col_wrap) begin
            col_index_in = col_start_ff;
            if (row_done) begin
               running_in = 1'b0;
            end else begin
               row_index_in = next_row;
            end
         end else begin
            col_index_in = next_col;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_index_ff   <= '0;
         col_index_ff   <= '0;
         col_start_ff   <= '0;
         row_limit_ff   <= '0;
         col_limit_ff   <= '0;
         base_a_ff      <= '0;
         base_b_ff      <= '0;
         base_result_ff <= '0;
         running_ff     <= 1'b0;
      end else begin
         row_index_ff   <= row_index_in;
         col_index_ff   <= col_index_in;
         col_start_ff   <= col_start_in;
         row_limit_ff   <= row_limit_in;
         col_limit_ff   <= col_limit_in;
         base_a_ff      <= base_a_in;
         base_b_ff      <= base_b_in;
         base_result_ff <= base_result_in;
         running_ff     <= running_in;
      end
   end

   // Data words of an active run go on to the back part.
   assign work_valid            = accept && req_kind && running_ff;
   assign work_word.row_index   = row_index_ff;
   assign work_word.col_index   = col_index_ff;
   assign work_word.base_a      = base_a_ff;
   assign work_word.base_b      = base_b_ff;
   assign work_word.base_result = base_result_ff;
   assign work_word.a_value     = req_a_value;
   assign work_word.b_value     = req_b_value;
   assign work_word.last        = col_wrap && row_done;

   // A run that ends without a new start word must end on a last data word.
   a_end_from_run: assert property (@(posedge clock) disable iff (reset)
      (running_ff && !running_in && !(accept && !req_kind)) |-> work_valid && work_word.last)
      else $error("run ended without a last word");
   a_no_work_idle: assert property (@(posedge clock) disable iff (reset)
      work_valid |-> running_ff)
      else $error("work issued with no run active");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      work_valid |-> !work_full)
      else $error("work pushed into full queue");

endmodule

### rtl/s2gt_queue.sv
module s2gt_queue #(
   parameter int WIDTH = 1,
   parameter int DEPTH = s2gt_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = count_ff == CNT_W'(DEPTH);
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

### rtl/s2gt_back.sv
module s2gt_back (
   input  logic                  clock,
   input  logic                  reset,
   input  s2gt_pkg::stride_type  strides,
   input  logic                  work_empty,
   input  s2gt_pkg::work_type    work_word,
   output logic                  work_pop,
   output logic                  res_push,
   output s2gt_pkg::result_type  res_word,
   input  logic                  res_full
);
   import s2gt_pkg::*;

   // Stage one: the six stride products, the bases and the compare bit.
   logic              s1_valid_ff;
   logic [ADDR_W-1:0] s1_a_row_ff, s1_a_col_ff;
   logic [ADDR_W-1:0] s1_b_row_ff, s1_b_col_ff;
   logic [ADDR_W-1:0] s1_r_row_ff, s1_r_col_ff;
   logic [ADDR_W-1:0] s1_base_a_ff, s1_base_b_ff, s1_base_r_ff;
   logic              s1_greater_ff;
   logic              s1_last_ff;
   logic              advance;

   // The stage moves when its slot is free or its word leaves.
   assign advance  = !s1_valid_ff || !res_full;
   assign work_pop = advance && !work_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= !work_empty;
      end
   end

   always_ff @(posedge clock) begin
      if (work_pop) begin
         s1_a_row_ff   <= work_word.row_index * strides.a_row;
         s1_a_col_ff   <= work_word.col_index * strides.a_col;
         s1_b_row_ff   <= work_word.row_index * strides.b_row;
         s1_b_col_ff   <= work_word.col_index * strides.b_col;
         s1_r_row_ff   <= work_word.row_index * strides.r_row;
         s1_r_col_ff   <= work_word.col_index * strides.r_col;
         s1_base_a_ff  <= work_word.base_a;
         s1_base_b_ff  <= work_word.base_b;
         s1_base_r_ff  <= work_word.base_result;
         s1_greater_ff <= fp_greater(work_word.a_value, work_word.b_value);
         s1_last_ff    <= work_word.last;
      end
   end

   // Stage two: the address sums feed the output queue.
   assign res_push                = s1_valid_ff && !res_full;
   assign res_word.a_address      = s1_base_a_ff + s1_a_row_ff + s1_a_col_ff;
   assign res_word.b_address      = s1_base_b_ff + s1_b_row_ff + s1_b_col_ff;
   assign res_word.result_address = s1_base_r_ff + s1_r_row_ff + s1_r_col_ff;
   assign res_word.greater        = s1_greater_ff;
   assign res_word.last           = s1_last_ff;

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && res_full) |=> s1_valid_ff && $stable(s1_last_ff))
      else $error("stalled stage lost its word");
   a_pop_room: assert property (@(posedge clock) disable iff (reset)
      work_pop |-> (!s1_valid_ff || res_push))
      else $error("stage overwritten");
   a_push_valid: assert property (@(posedge clock) disable iff (reset)
      res_push |-> s1_valid_ff)
      else $error("result pushed without a word");

endmodule

### rtl/s2gt_regs.sv
module s2gt_regs (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [s2gt_pkg::PADDR_W-1:0]  paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready,
   output s2gt_pkg::stride_type          strides
);
   import s2gt_pkg::*;

   stride_type    regs_ff, regs_in;
   reg_index_type sel;
   logic          wr_en;

   assign pready  = 1'b1;
   assign sel     = reg_index_type'(paddr[PADDR_W-1:2]);
   assign wr_en   = psel && penable && pwrite && pready && (paddr[1:0] == 2'b00);
   assign strides = regs_ff;

   // Register write decode.
   always_comb begin
      regs_in = regs_ff;
      if (wr_en) begin
         unique case (sel)
            REG_A_ROW: regs_in.a_row = pwdata;
            REG_A_COL: regs_in.a_col = pwdata;
            REG_B_ROW: regs_in.b_row = pwdata;
            REG_B_COL: regs_in.b_col = pwdata;
            REG_R_ROW: regs_in.r_row = pwdata;
            REG_R_COL: regs_in.r_col = pwdata;
            default:   regs_in = regs_ff;
         endcase
      end
   end

   // Register read decode.
   always_comb begin
      unique case (sel)
         REG_A_ROW: prdata = regs_ff.a_row;
         REG_A_COL: prdata = regs_ff.a_col;
         REG_B_ROW: prdata = regs_ff.b_row;
         REG_B_COL: prdata = regs_ff.b_col;
         REG_R_ROW: prdata = regs_ff.r_row;
         REG_R_COL: prdata = regs_ff.r_col;
         default:   prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.a_row <= '0;
         regs_ff.a_col <= 32'd1;
         regs_ff.b_row <= '0;
         regs_ff.b_col <= 32'd1;
         regs_ff.r_row <= '0;
         regs_ff.r_col <= 32'd1;
      end else begin
         regs_ff <= regs_in;
      end
   end

endmodule

### rtl/strided_2d_greater_than_top.sv
// Two-dimensional strided "greater than" over IEEE doubles. A start word (kind 0) loads the
// row and column ranges and three bases; each following data word (kind 1) gives one result
// word with the A, B and result element addresses (base + row*row_stride + col*col_stride,
// wrapping at 32 bits), the compare bit, the compare as double 1.0 or 0.0, and a last flag.
// Data words with no active run and all start words give no result. The block takes one
// word per cycle unless req_full is high; a result passes the work queue, the multiply stage
// and the output queue before it can be popped. Strides are written over the APB port at byte
// address 4*i; the user must write them only while idle; the block does not enforce this.
module strided_2d_greater_than_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic                          req_kind,
   input  logic [s2gt_pkg::ADDR_W-1:0]   req_row_first,
   input  logic [s2gt_pkg::ADDR_W-1:0]   req_row_end,
   input  logic [s2gt_pkg::ADDR_W-1:0]   req_col_first,
   input  logic [s2gt_pkg::ADDR_W-1:0]   req_col_end,
   input  logic [s2gt_pkg::ADDR_W-1:0]   req_a_base,
   input  logic [s2gt_pkg::ADDR_W-1:0]   req_b_base,
   input  logic [s2gt_pkg::ADDR_W-1:0]   req_result_base,
   input  logic [s2gt_pkg::VALUE_W-1:0]  req_a_value,
   input  logic [s2gt_pkg::VALUE_W-1:0]  req_b_value,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [s2gt_pkg::ADDR_W-1:0]   rsp_a_address,
   output logic [s2gt_pkg::ADDR_W-1:0]   rsp_b_address,
   output logic [s2gt_pkg::ADDR_W-1:0]   rsp_result_address,
   output logic                          rsp_greater,
   output logic [s2gt_pkg::VALUE_W-1:0]  rsp_result_value,
   output logic                          rsp_last,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [s2gt_pkg::PADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);
   import s2gt_pkg::*;

   stride_type strides;
   logic       work_push, work_full, work_empty, work_pop;
   work_type   work_in, work_out;
   logic       res_push, res_full;
   result_type res_in, res_out;

   s2gt_regs u_regs (
      .clock, .reset,
      .psel(csr_psel), .penable(csr_penable), .pwrite(csr_pwrite),
      .paddr(csr_paddr), .pwdata(csr_pwdata), .prdata(csr_prdata),
      .pready(csr_pready), .strides
   );

   s2gt_front u_front (
      .clock, .reset, .req_push, .req_full, .req_kind,
      .req_row_first, .req_row_end, .req_col_first, .req_col_end,
      .req_a_base, .req_b_base, .req_result_base, .req_a_value, .req_b_value,
      .work_valid(work_push), .work_word(work_in), .work_full
   );

   s2gt_queue #(.WIDTH($bits(work_type)), .DEPTH(QUEUE_DEPTH)) u_work_q (
      .clock, .reset, .push(work_push), .push_data(work_in), .full(work_full),
      .pop(work_pop), .pop_data(work_out), .empty(work_empty)
   );

   s2gt_back u_back (
      .clock, .reset, .strides, .work_empty, .work_word(work_out), .work_pop,
      .res_push, .res_word(res_in), .res_full
   );

   s2gt_queue #(.WIDTH($bits(result_type)), .DEPTH(OUT_DEPTH)) u_out_q (
      .clock, .reset, .push(res_push), .push_data(res_in), .full(res_full),
      .pop(rsp_pop), .pop_data(res_out), .empty(rsp_empty)
   );

   assign rsp_a_address      = res_out.a_address;
   assign rsp_b_address      = res_out.b_address;
   assign rsp_result_address = res_out.result_address;
   assign rsp_greater        = res_out.greater;
   assign rsp_result_value   = res_out.greater ? ONE_BITS : '0;
   assign rsp_last           = res_out.last;

endmodule

### verif/strided_2d_greater_than_top_tb.sv
module strided_2d_greater_than_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import s2gt_pkg::*;

   localparam logic KIND_START = 1'b0;
   localparam logic KIND_DATA  = 1'b1;
   localparam int DRAIN_CYCLES = 10;

   typedef struct {
      logic               kind;
      logic [31:0]        row_first;
      logic [31:0]        row_end;
      logic [31:0]        col_first;
      logic [31:0]        col_end;
      logic [31:0]        a_base;
      logic [31:0]        b_base;
      logic [31:0]        result_base;
      logic [63:0]        a_value;
      logic [63:0]        b_value;
   } req_word_type;

   typedef struct {
      logic [31:0] a_address;
      logic [31:0] b_address;
      logic [31:0] result_address;
      logic        greater;
      logic [63:0] result_value;
      logic        last;
   } rsp_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   logic req_kind = 1'b0;
   logic [31:0] req_row_first = '0, req_row_end = '0, req_col_first = '0, req_col_end = '0;
   logic [31:0] req_a_base = '0, req_b_base = '0, req_result_base = '0;
   logic [63:0] req_a_value = '0, req_b_value = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic [31:0] rsp_a_address, rsp_b_address, rsp_result_address;
   logic rsp_greater;
   logic [63:0] rsp_result_value;
   logic rsp_last;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [PADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   strided_2d_greater_than_top DUT (.*);

   // Clock: 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Predictor state: strides and loop position.
   logic [31:0] stride_q [NUM_REGS];
   logic signed [31:0] row_idx, col_idx, col_origin, row_lim, col_lim;
   logic [31:0] base_a_q, base_b_q, base_r_q;
   logic        run_active;

   req_word_type pending_words [$];
   rsp_word_type expected_words [$];
   int        send_gap;
   int        pop_gap;
   int        error_count;
   bit        hold_sender;

   // IEEE "greater than" worked out from sign and magnitude.
   function automatic logic double_greater(logic [63:0] a, logic [63:0] b);
      if ((a[62:52] == 11'h7FF && a[51:0] != 0) || (b[62:52] == 11'h7FF && b[51:0] != 0))
         return 1'b0;
      if (a[62:0] == 0 && b[62:0] == 0)
         return 1'b0;
      if (a[63] != b[63])
         return b[63];
      if (!a[63])
         return a[62:0] > b[62:0];
      return a[62:0] < b[62:0];
   endfunction

   // Advance the loop model by one accepted word and queue any result.
   task automatic predict_word(req_word_type w);
      rsp_word_type r;
      if (w.kind == KIND_START) begin
         row_idx = w.row_first;
         col_idx = w.col_first;
         col_origin = w.col_first;
         row_lim = w.row_end;
         col_lim = w.col_end;
         base_a_q = w.a_base;
         base_b_q = w.b_base;
         base_r_q = w.result_base;
         run_active = ($signed(w.row_first) < $signed(w.row_end)) &&
                      ($signed(w.col_first) < $signed(w.col_end));
      end else if (run_active) begin
         r.a_address = base_a_q + row_idx * stride_q[REG_A_ROW] + col_idx * stride_q[REG_A_COL];
         r.b_address = base_b_q + row_idx * stride_q[REG_B_ROW] + col_idx * stride_q[REG_B_COL];
         r.result_address = base_r_q + row_idx * stride_q[REG_R_ROW] +
                            col_idx * stride_q[REG_R_COL];
         r.greater = double_greater(w.a_value, w.b_value);
         r.result_value = r.greater ? ONE_BITS : 64'd0;
         r.last = 1'b0;
         if (col_idx + 1 >= col_lim) begin
            col_idx = col_origin;
            if (row_idx + 1 >= row_lim) begin
               r.last = 1'b1;
               run_active = 1'b0;
            end else begin
               row_idx = row_idx + 1;
            end
         end else begin
            col_idx = col_idx + 1;
         end
         expected_words.push_back(r);
      end
   endtask

   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // Driver: present the head word, drop it once accepted.
   logic accepted_now;
   always @(posedge clock) begin
      accepted_now <= req_push && !req_full && !reset;
   end

   always @(posedge clock) begin
      if (!reset && req_push && !req_full) begin
         predict_word(pending_words.pop_front());
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else if (req_push && !accepted_now) begin
         // Word not yet taken: hold it.
      end else if (send_gap > 0) begin
         send_gap--;
         req_push <= 1'b0;
      end else if (pending_words.size() > 0 && !hold_sender) begin
         req_push <= 1'b1;
         req_kind <= pending_words[0].kind;
         req_row_first <= pending_words[0].row_first;
         req_row_end <= pending_words[0].row_end;
         req_col_first <= pending_words[0].col_first;
         req_col_end <= pending_words[0].col_end;
         req_a_base <= pending_words[0].a_base;
         req_b_base <= pending_words[0].b_base;
         req_result_base <= pending_words[0].result_base;
         req_a_value <= pending_words[0].a_value;
         req_b_value <= pending_words[0].b_value;
         send_gap = pick_gap();
      end else begin
         req_push <= 1'b0;
      end
   end

   // Monitor: compare each popped word with the oldest expectation.
   always @(posedge clock) begin
      rsp_word_type e;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected result word, a_address %h", $realtime, rsp_a_address);
            error_count++;
         end else begin
            e = expected_words.pop_front();
            if (rsp_a_address !== e.a_address) begin
               $display("%0t: a_address expected %h actual %h", $realtime, e.a_address,
                        rsp_a_address);
               error_count++;
            end
            if (rsp_b_address !== e.b_address) begin
               $display("%0t: b_address expected %h actual %h", $realtime, e.b_address,
                        rsp_b_address);
               error_count++;
            end
            if (rsp_result_address !== e.result_address) begin
               $display("%0t: result_address expected %h actual %h", $realtime,
                        e.result_address, rsp_result_address);
               error_count++;
            end
            if (rsp_greater !== e.greater) begin
               $display("%0t: greater expected %b actual %b", $realtime, e.greater, rsp_greater);
               error_count++;
            end
            if (rsp_result_value !== e.result_value) begin
               $display("%0t: result_value expected %h actual %h", $realtime, e.result_value,
                        rsp_result_value);
               error_count++;
            end
            if (rsp_last !== e.last) begin
               $display("%0t: last expected %b actual %b", $realtime, e.last, rsp_last);
               error_count++;
            end
         end
      end
   end

   // Random stalls on the result side.
   always @(negedge clock) begin
      if (pop_gap > 0) begin
         pop_gap--;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
         pop_gap = pick_gap();
      end
   end

   // Stride write through the configuration port while the block is idle.
   task automatic write_stride(reg_index_type idx, logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= PADDR_W'(4 * int'(idx));
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      stride_q[idx] = value;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_words.size() > 0 || req_push || expected_words.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic req_word_type start_word(int rf, int re, int cf, int ce,
                                               logic [31:0] ab, logic [31:0] bb,
                                               logic [31:0] rb);
      req_word_type w;
      w = '{default: '0};
      w.kind = KIND_START;
      w.row_first = rf; w.row_end = re; w.col_first = cf; w.col_end = ce;
      w.a_base = ab; w.b_base = bb; w.result_base = rb;
      w.a_value = {$urandom, $urandom};
      w.b_value = {$urandom, $urandom};
      return w;
   endfunction

   function automatic logic [63:0] random_double();
      case ($urandom_range(0, 7))
         0: return 64'h7FF0_0000_0000_0000 | ($urandom_range(0, 1) ? 64'h8000_0000_0000_0000 : 0);
         1: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 11'h7FF, 20'h0, 32'($urandom) | 32'd1};
         2: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 63'd0};
         3: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 11'd0, 20'($urandom), 32'($urandom)};
         4: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 11'h3FF, 50'd0, 2'($urandom)};
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic req_word_type data_word(logic [63:0] a, logic [63:0] b);
      req_word_type w;
      w = '{default: '0};
      w.kind = KIND_DATA;
      w.row_first = $urandom; w.row_end = $urandom; w.col_first = $urandom;
      w.col_end = $urandom; w.a_base = $urandom; w.b_base = $urandom;
      w.result_base = $urandom;
      w.a_value = a;
      w.b_value = b;
      return w;
   endfunction

   function automatic logic [31:0] random_stride();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'hFFFF_FFFF;
         3: return 32'($urandom);
         default: return 32'($signed($urandom_range(0, 40)) - 20);
      endcase
   endfunction

   // Stimulus and end of run.
   initial begin
      int rows, cols, rf, cf;
      stride_q[REG_A_ROW] = 0; stride_q[REG_A_COL] = 1;
      stride_q[REG_B_ROW] = 0; stride_q[REG_B_COL] = 1;
      stride_q[REG_R_ROW] = 0; stride_q[REG_R_COL] = 1;
      row_idx = 0; col_idx = 0; col_origin = 0; row_lim = 0; col_lim = 0;
      base_a_q = 0; base_b_q = 0; base_r_q = 0; run_active = 1'b0;
      send_gap = 0; pop_gap = 0; error_count = 0; hold_sender = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: data with no run, empty ranges, extremes, abort mid-run.
      pending_words.push_back(data_word(64'h3FF0_0000_0000_0000, 64'd0));
      pending_words.push_back(start_word(5, 5, 0, 3, 0, 0, 0));
      pending_words.push_back(data_word(64'h3FF0_0000_0000_0000, 64'd0));
      pending_words.push_back(start_word(0, 2, 7, 7, 0, 0, 0));
      pending_words.push_back(start_word(32'h7FFF_FFFE, 32'h7FFF_FFFF, 32'h7FFF_FFFD,
                                         32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                                         32'hFFFF_FFFF));
      pending_words.push_back(data_word(64'h7FF8_0000_0000_0000, 64'd0));
      pending_words.push_back(data_word(64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000));
      pending_words.push_back(data_word(64'h3FF0_0000_0000_0000, 64'h8000_0000_0000_0000));
      pending_words.push_back(start_word(32'h8000_0000, 32'h8000_0002, 32'h8000_0000,
                                         32'h8000_0002, 0, 0, 0));
      pending_words.push_back(data_word(64'hFFF0_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF));
      pending_words.push_back(data_word(64'h7FF0_0000_0000_0000, 64'h7FEF_FFFF_FFFF_FFFF));
      pending_words.push_back(start_word(0, 3, 0, 2, 10, 20, 30));
      pending_words.push_back(data_word(64'hBFF0_0000_0000_0000, 64'hC000_0000_0000_0000));
      pending_words.push_back(start_word(0, 1, 0, 1, 0, 0, 0));
      pending_words.push_back(data_word(64'd1, 64'd0));
      pending_words.push_back(data_word(64'd1, 64'd0));
      wait_idle();

      // Phases of random strides and random runs.
      for (int phase = 0; phase < 8; phase++) begin
         if (phase == 1) begin
            write_stride(REG_A_ROW, 32'h8000_0000); write_stride(REG_A_COL, 32'h7FFF_FFFF);
            write_stride(REG_B_ROW, 32'h7FFF_FFFF); write_stride(REG_B_COL, 32'h8000_0000);
            write_stride(REG_R_ROW, 32'hFFFF_FFFF); write_stride(REG_R_COL, 32'h0);
         end else if (phase > 1) begin
            write_stride(REG_A_ROW, random_stride()); write_stride(REG_A_COL, random_stride());
            write_stride(REG_B_ROW, random_stride()); write_stride(REG_B_COL, random_stride());
            write_stride(REG_R_ROW, random_stride()); write_stride(REG_R_COL, random_stride());
         end
         for (int n = 0; n < 240; ) begin
            rows = $urandom_range(1, 4);
            cols = $urandom_range(1, 6);
            if ($urandom_range(0, 9) == 0) begin
               rf = $urandom; cf = $urandom;
            end else begin
               rf = $signed($urandom_range(0, 20)) - 10;
               cf = $signed($urandom_range(0, 20)) - 10;
            end
            if ($urandom_range(0, 19) == 0) begin
               // Empty or reversed range.
               pending_words.push_back(start_word(rf, rf - $urandom_range(0, 3), cf, cf + cols,
                                                  $urandom, $urandom, $urandom));
            end else if ($urandom_range(0, 19) == 0) begin
               pending_words.push_back(start_word(32'h7FFF_FFFF - rows, 32'h7FFF_FFFF,
                                                  32'h7FFF_FFFF - cols, 32'h7FFF_FFFF,
                                                  $urandom, $urandom, $urandom));
            end else begin
               pending_words.push_back(start_word(rf, rf + rows, cf, cf + cols,
                                                  $urandom, $urandom, $urandom));
            end
            n++;
            // Mostly full runs, sometimes cut short or overrun.
            for (int k = rows * cols + $signed($urandom_range(0, 4)) - 2; k > 0; k--) begin
               pending_words.push_back(data_word(random_double(),
                                                 $urandom_range(0, 3) == 0 ?
                                                 random_double() : {$urandom, $urandom}));
               n++;
            end
         end
         if (phase == 3) begin
            // Sender waits until every expected result has drained.
            while (pending_words.size() > 120) @(posedge clock);
            hold_sender = 1'b1;
            while (req_push || expected_words.size() > 0) @(posedge clock);
            hold_sender = 1'b0;
         end
         wait_idle();
      end

      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #4ms;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
